/* rtl/core/fqs_pkg.sv */
// Shared types and constants for the FIFO queue with search.
// Depends on nothing; every other file of the block but fqs_ram imports it.
package fqs_pkg;

    // Queue geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 8;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Field widths of the request and result items
    localparam int VALUE_W = 8;

    // Operation codes carried in a request
    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One request
    typedef struct packed {
        t_op                op;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    // One result
    typedef struct packed {
        t_status            status;
        logic               found;
        logic [CNT_W-1:0]   count;
        logic               has_items;
        logic [VALUE_W-1:0] front_value;
        logic [VALUE_W-1:0] rear_value;
    } t_out_item;

    // Entry store access issued by the sequencer
    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]     raddr;
    } t_ram_req;

endpackage

/* rtl/core/fqs_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
module fqs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

/* rtl/core/fqs_ctrl.sv */
// Queue sequencer: head/tail/count bookkeeping, entry store accesses, search scan.
// Depends on fqs_pkg; drives the entry store in fqs_ram.
module fqs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  fqs_pkg::t_in_item             i_in,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output fqs_pkg::t_out_item            o_res,
    output fqs_pkg::t_ram_req             o_ram,
    input  logic [fqs_pkg::DATA_WIDTH-1:0] i_ram_rdata
);
    import fqs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ_RD,
        S_SCAN,
        S_RESP
    } t_state;

    t_state                r_state,     n_state;
    logic [ADDR_W-1:0]     r_head,      n_head;
    logic [ADDR_W-1:0]     r_tail,      n_tail;
    logic [CNT_W-1:0]      r_count,     n_count;
    logic [DATA_WIDTH-1:0] r_front,     n_front;
    logic [DATA_WIDTH-1:0] r_rear,      n_rear;
    logic [DATA_WIDTH-1:0] r_key,       n_key;
    logic                  r_found,     n_found;
    t_status               r_status,    n_status;
    logic [ADDR_W-1:0]     r_scan_slot, n_scan_slot;
    logic [CNT_W-1:0]      r_scan_left, n_scan_left;

    logic                  w_accept;
    logic [DATA_WIDTH-1:0] w_key;
    logic                  w_has;

    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] s);
        return (s == ADDR_W'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    // A new request enters when idle, or while the finished result is handed off
    assign o_in_ready  = (r_state == S_IDLE) || ((r_state == S_RESP) && i_res_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_key       = DATA_WIDTH'(i_in.value);
    assign o_res_valid = (r_state == S_RESP);

    // Result view of the current queue state
    assign w_has = (r_count != '0);
    always_comb begin
        o_res.status      = r_status;
        o_res.found       = r_found;
        o_res.count       = r_count;
        o_res.has_items   = w_has;
        o_res.front_value = w_has ? VALUE_W'(r_front) : '0;
        o_res.rear_value  = w_has ? VALUE_W'(r_rear) : '0;
    end

    // Next-state logic. The only write is an enqueue at the tail; reads of the
    // head or scan slots always follow in later cycles, so no forwarding is needed.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_front     = r_front;
        n_rear      = r_rear;
        n_key       = r_key;
        n_found     = r_found;
        n_status    = r_status;
        n_scan_slot = r_scan_slot;
        n_scan_left = r_scan_left;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_tail;
        o_ram.wdata = w_key;
        o_ram.raddr = r_scan_slot;

        unique case (r_state)
            S_IDLE: begin
                n_state = S_IDLE;
            end
            S_DEQ_RD: begin
                // new front arrives from the store
                n_front = i_ram_rdata;
                n_state = S_RESP;
            end
            S_SCAN: begin
                // compare the entry read last cycle, issue the next read
                n_found = r_found | (i_ram_rdata == r_key);
                if (r_scan_left != '0) begin
                    o_ram.raddr = r_scan_slot;
                    n_scan_slot = next_slot(r_scan_slot);
                    n_scan_left = r_scan_left - 1'b1;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Request entry
        if (w_accept) begin
            n_status = ST_OK;
            n_found  = 1'b0;
            n_state  = S_RESP;
            unique case (i_in.op)
                OP_ENQ: begin
                    if (r_count == CNT_W'(DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        o_ram.we = 1'b1;
                        n_tail   = next_slot(r_tail);
                        n_count  = r_count + 1'b1;
                        n_rear   = w_key;
                        if (r_count == '0) begin
                            n_front = w_key;
                        end
                    end
                end
                OP_DEQ: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_head  = next_slot(r_head);
                        n_count = r_count - 1'b1;
                        // fetch the new front unless the queue drains
                        if (r_count != CNT_W'(1)) begin
                            o_ram.raddr = next_slot(r_head);
                            n_state     = S_DEQ_RD;
                        end
                    end
                end
                OP_SEARCH: begin
                    n_key = w_key;
                    if (r_count != '0) begin
                        o_ram.raddr = r_head;
                        n_scan_slot = next_slot(r_head);
                        n_scan_left = r_count - 1'b1;
                        n_state     = S_SCAN;
                    end
                end
                OP_CLEAR: begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
        r_front     <= n_front;
        r_rear      <= n_rear;
        r_key       <= n_key;
        r_found     <= n_found;
        r_status    <= n_status;
        r_scan_slot <= n_scan_slot;
        r_scan_left <= n_scan_left;
    end

endmodule

/* rtl/core/fqs_out_reg.sv */
// Output register stage that decouples the sequencer from the result receiver.
// Depends on fqs_pkg for the result type.
module fqs_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  fqs_pkg::t_out_item i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output fqs_pkg::t_out_item o_item
);
    import fqs_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // Load whenever the slot is empty or being drained this cycle
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* rtl/core/fifo_queue_with_search.sv */
// FIFO queue with search: top level.
// Depends on fqs_pkg, fqs_ram, fqs_ctrl and fqs_out_reg.
//
// Request channel (i_in_valid / o_in_ready / i_in) carries an operation and a
// value: enqueue, dequeue, search or clear. Every request yields exactly one
// result on the result channel (o_out_valid / i_out_ready / o_out) with the
// status, the search hit flag, the entry count and the front and rear values.
//
// Entries live in a 16 x 8 synchronous RAM with registered read data.
// Enqueue, clear, rejected requests, a dequeue that empties the queue and a
// search of an empty queue go straight to the result, so they sustain one
// request per cycle while the receiver keeps up. A dequeue that leaves
// entries behind first reads the new front. A search reads one stored entry
// per cycle through the single read port; o_out comes from a result register.
//
// Reset (i_rst_n low at a clock edge) empties the queue; RAM contents are not
// cleared and are never shown before being written. When the receiver stalls,
// the output register holds one result, the sequencer holds the next, and
// then o_in_ready drops until results drain.
module fifo_queue_with_search (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fqs_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fqs_pkg::t_out_item o_out
);
    import fqs_pkg::*;

    logic                  w_res_valid;
    logic                  w_res_ready;
    t_out_item             w_res;
    t_ram_req              w_ram;
    logic [DATA_WIDTH-1:0] w_rdata;

    // Sequencer
    fqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_ram       (w_ram),
        .i_ram_rdata (w_rdata)
    );

    // Entry store
    fqs_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    // Result register
    fqs_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .o_ready (w_res_ready),
        .i_item  (w_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out)
    );

endmodule

/* rtl/core/fqs_checker.sv */
// Port-level checks for the FIFO queue with search, bound to the top level.
// Depends on fqs_pkg.
module fqs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input fqs_pkg::t_out_item o_out
);
    import fqs_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // The occupancy flag agrees with the count
    a_has_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.has_items == (o_out.count != '0)))
        else $error("has_items disagrees with count");

    // A full rejection reports a full queue
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_FULL) |-> (o_out.count == CNT_W'(DEPTH)))
        else $error("full status with room left");

    // An empty rejection reports an empty queue
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_EMPTY) |-> (o_out.count == '0))
        else $error("empty status with entries stored");

    // A search hit needs a stored entry
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.found |-> o_out.has_items && (o_out.status == ST_OK))
        else $error("search hit on empty queue");

endmodule

bind fifo_queue_with_search fqs_checker u_fqs_checker (.*);

/* verif/tb_top.sv */
// Self-checking testbench for fifo_queue_with_search: directed table, then random requests.
// Depends on fqs_pkg (request/result types, op and status codes) and the top-level RTL.
`timescale 1ns / 1ps

module tb_top;
    import fqs_pkg::*;

    localparam int unsigned RANDOM_PER_PHASE = 350;
    localparam int unsigned RX_HOLD_CYCLES   = 300;
    localparam int unsigned DRAIN_CYCLES     = 40;
    localparam int unsigned NUM_ROWS         = 25;

    // One row of the directed table; reps repeats the same request
    typedef struct {
        t_op                op;
        logic [VALUE_W-1:0] value;
        int unsigned        reps;
        bit                 typed;
        t_out_item          want;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out;

    // Shadow copy of the queue, advanced once per accepted request
    logic [DATA_WIDTH-1:0] shadow_store [DEPTH];
    int unsigned           shadow_head  = 0;
    int unsigned           shadow_tail  = 0;
    int unsigned           shadow_count = 0;

    t_out_item   pending_results [$];
    int unsigned error_count     = 0;
    int unsigned tx_idle_pct     = 26;
    int unsigned rx_idle_pct     = 81;
    bit          rx_hold_pending = 1'b0;
    bit          filling         = 1'b1;

    // Directed requests: empty-queue corners, fill to full, wrap, clear
    t_dir_row directed_rows [NUM_ROWS] = '{
        '{OP_DEQ,    8'h00,  1, 1'b1, '{ST_EMPTY, 1'b0, 5'd0,  1'b0, 8'h00, 8'h00}},
        '{OP_SEARCH, 8'h00,  1, 1'b1, '{ST_OK,    1'b0, 5'd0,  1'b0, 8'h00, 8'h00}},
        '{OP_CLEAR,  8'h00,  1, 1'b1, '{ST_OK,    1'b0, 5'd0,  1'b0, 8'h00, 8'h00}},
        '{OP_ENQ,    8'hFF,  1, 1'b1, '{ST_OK,    1'b0, 5'd1,  1'b1, 8'hFF, 8'hFF}},
        '{OP_ENQ,    8'h00,  1, 1'b1, '{ST_OK,    1'b0, 5'd2,  1'b1, 8'hFF, 8'h00}},
        '{OP_SEARCH, 8'hFF,  1, 1'b1, '{ST_OK,    1'b1, 5'd2,  1'b1, 8'hFF, 8'h00}},
        '{OP_SEARCH, 8'h00,  1, 1'b1, '{ST_OK,    1'b1, 5'd2,  1'b1, 8'hFF, 8'h00}},
        '{OP_SEARCH, 8'h5A,  1, 1'b1, '{ST_OK,    1'b0, 5'd2,  1'b1, 8'hFF, 8'h00}},
        '{OP_DEQ,    8'h00,  1, 1'b1, '{ST_OK,    1'b0, 5'd1,  1'b1, 8'h00, 8'h00}},
        '{OP_DEQ,    8'h00,  1, 1'b1, '{ST_OK,    1'b0, 5'd0,  1'b0, 8'h00, 8'h00}},
        '{OP_ENQ,    8'h01,  1, 1'b0, '0},
        '{OP_ENQ,    8'h80, 14, 1'b0, '0},
        '{OP_ENQ,    8'h7E,  1, 1'b0, '0},
        '{OP_ENQ,    8'h33,  1, 1'b1, '{ST_FULL,  1'b0, 5'd16, 1'b1, 8'h01, 8'h7E}},
        '{OP_SEARCH, 8'h7E,  1, 1'b0, '0},
        '{OP_SEARCH, 8'h01,  1, 1'b0, '0},
        '{OP_SEARCH, 8'h02,  1, 1'b0, '0},
        '{OP_DEQ,    8'h00,  1, 1'b0, '0},
        '{OP_ENQ,    8'hC3,  1, 1'b0, '0},
        '{OP_SEARCH, 8'hC3,  1, 1'b0, '0},
        '{OP_CLEAR,  8'hAA,  1, 1'b1, '{ST_OK,    1'b0, 5'd0,  1'b0, 8'h00, 8'h00}},
        '{OP_SEARCH, 8'hC3,  1, 1'b1, '{ST_OK,    1'b0, 5'd0,  1'b0, 8'h00, 8'h00}},
        '{OP_ENQ,    8'h42,  1, 1'b1, '{ST_OK,    1'b0, 5'd1,  1'b1, 8'h42, 8'h42}},
        '{OP_DEQ,    8'h00,  1, 1'b1, '{ST_OK,    1'b0, 5'd0,  1'b0, 8'h00, 8'h00}},
        '{OP_DEQ,    8'h00,  1, 1'b1, '{ST_EMPTY, 1'b0, 5'd0,  1'b0, 8'h00, 8'h00}}
    };

    fifo_queue_with_search uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #4 i_clk = ~i_clk;

    // Apply one request to the shadow queue and return the result it should give
    function automatic t_out_item queue_outcome(t_in_item req);
        t_out_item             res;
        logic [DATA_WIDTH-1:0] val;
        int unsigned           slot;
        res = '0;
        res.status = ST_OK;
        val = req.value[DATA_WIDTH-1:0];
        case (req.op)
            OP_ENQ: begin
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_store[shadow_tail] = val;
                    shadow_tail = (shadow_tail + 1) % DEPTH;
                    shadow_count++;
                end
            end
            OP_DEQ: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                end
            end
            OP_SEARCH: begin
                slot = shadow_head;
                for (int k = 0; k < shadow_count; k++) begin
                    if (shadow_store[slot] == val) res.found = 1'b1;
                    slot = (slot + 1) % DEPTH;
                end
            end
            OP_CLEAR: begin
                shadow_head  = 0;
                shadow_tail  = 0;
                shadow_count = 0;
            end
        endcase
        res.count     = CNT_W'(shadow_count);
        res.has_items = (shadow_count != 0);
        if (shadow_count != 0) begin
            res.front_value = VALUE_W'(shadow_store[shadow_head]);
            res.rear_value  = VALUE_W'(shadow_store[(shadow_tail + DEPTH - 1) % DEPTH]);
        end
        return res;
    endfunction

    // Random request; the fill/drain trend flips near full and empty so both get hit
    function automatic t_in_item random_request();
        t_in_item    req;
        int unsigned pick;
        int unsigned enq_share;
        pick = $urandom_range(0, 99);
        if (filling && shadow_count == DEPTH && $urandom_range(0, 3) == 0) begin
            filling = 1'b0;
        end else if (!filling && shadow_count == 0 && $urandom_range(0, 3) == 0) begin
            filling = 1'b1;
        end
        enq_share = filling ? 75 : 25;
        req.value = VALUE_W'($urandom_range(0, 255));
        if (pick < 1) begin
            req.op = OP_CLEAR;
        end else if (pick < 26) begin
            req.op = OP_SEARCH;
            // on a non-empty queue, half the searches look for a value that is stored
            if (shadow_count != 0 && $urandom_range(0, 1) == 1) begin
                req.value = VALUE_W'(shadow_store[(shadow_head
                    + $urandom_range(0, shadow_count - 1)) % DEPTH]);
            end
        end else if ($urandom_range(0, 99) < enq_share) begin
            req.op = OP_ENQ;
        end else begin
            req.op = OP_DEQ;
        end
        return req;
    endfunction

    // Offer one request at the falling edge, hold it until accepted
    task automatic send_request(input t_in_item req, input bit typed,
                                input t_out_item typed_result);
        t_out_item predicted;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in       = req;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = queue_outcome(req);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %p", $time, o_out);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status",      8'(want.status),    8'(o_out.status));
                compare_field("found",       8'(want.found),     8'(o_out.found));
                compare_field("count",       8'(want.count),     8'(o_out.count));
                compare_field("has_items",   8'(want.has_items), 8'(o_out.has_items));
                compare_field("front_value", want.front_value,   o_out.front_value);
                compare_field("rear_value",  want.rear_value,    o_out.rear_value);
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (rx_hold_pending) begin
                rx_hold_pending = 1'b0;
                i_out_ready = 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Stimulus
    initial begin
        t_in_item req;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int r = 0; r < NUM_ROWS; r++) begin
            req.op    = directed_rows[r].op;
            req.value = directed_rows[r].value;
            repeat (directed_rows[r].reps) begin
                send_request(req, directed_rows[r].typed, directed_rows[r].want);
            end
        end

        // random phases: slow receiver, slow sender, then full rate with a hold-off
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin tx_idle_pct = 26; rx_idle_pct = 81; end
                1: begin tx_idle_pct = 81; rx_idle_pct = 26; end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    rx_hold_pending = 1'b1;
                end
            endcase
            repeat (RANDOM_PER_PHASE) send_request(random_request(), 1'b0, '0);
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;

        // drain, then allow for any stray late result
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("PASS fifo_queue_with_search");
        end else begin
            $display("FAIL fifo_queue_with_search");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("FAIL fifo_queue_with_search");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/fqs_pkg.sv
rtl/core/fqs_ram.sv
rtl/core/fqs_ctrl.sv
rtl/core/fqs_out_reg.sv
rtl/core/fifo_queue_with_search.sv
rtl/core/fqs_checker.sv
verif/tb_top.sv
